/* rtl/jac_pkg.sv */
// Shared constants and types for the Jacobi symbol block.
package jac_pkg;

    localparam int unsigned OPERAND_WIDTH_DEF = 64;
    localparam int unsigned FIELD_WIDTH       = 64;
    localparam int unsigned S_TDATA_WIDTH     = 2 * FIELD_WIDTH;
    localparam int unsigned M_TDATA_WIDTH     = 8;

    // Two's-complement symbol codes
    localparam logic [1:0] SYM_ZERO = 2'b00;
    localparam logic [1:0] SYM_POS  = 2'b01;
    localparam logic [1:0] SYM_NEG  = 2'b11;

    // Residues that decide the sign flips
    localparam logic [2:0] MOD8_THREE = 3'd3;
    localparam logic [2:0] MOD8_FIVE  = 3'd5;
    localparam logic [1:0] MOD4_THREE = 2'd3;

    typedef struct packed {
        logic start;   // load operands and begin
        logic ack;     // result taken, return to idle
    } jac_ctrl_t;

    typedef struct packed {
        logic       idle;
        logic       done;
        logic [1:0] symbol;
    } jac_stat_t;

endpackage

/* rtl/jac_core.sv */
// Iterative binary Jacobi engine around one shared subtractor.
module jac_core #(
    parameter int unsigned OPERAND_WIDTH = jac_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  jac_pkg::jac_ctrl_t         ctrl,
    input  logic [OPERAND_WIDTH-1:0]   op_a,
    input  logic [OPERAND_WIDTH-1:0]   op_n,
    output jac_pkg::jac_stat_t         stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [OPERAND_WIDTH-1:0]   a_reg, a_next;
    logic [OPERAND_WIDTH-1:0]   n_reg, n_next;
    logic                       neg_reg, neg_next;
    logic [1:0]                 sym_reg, sym_next;

    logic [OPERAND_WIDTH:0]     diff;
    logic                       borrow;

    // Shared subtractor: its borrow doubles as the a < n compare
    assign diff   = {1'b0, a_reg} - {1'b0, n_reg};
    assign borrow = diff[OPERAND_WIDTH];

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        n_next     = n_reg;
        neg_next   = neg_reg;
        sym_next   = sym_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    a_next   = op_a;
                    n_next   = op_n;
                    neg_next = 1'b0;
                    if (!op_n[0]) begin
                        sym_next   = jac_pkg::SYM_ZERO;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (a_reg == '0) begin
                    if (n_reg == OPERAND_WIDTH'(1)) begin
                        sym_next = neg_reg ? jac_pkg::SYM_NEG : jac_pkg::SYM_POS;
                    end else begin
                        sym_next = jac_pkg::SYM_ZERO;
                    end
                    state_next = ST_DONE;
                end else if (!a_reg[0]) begin
                    // halve a; (2/n) is -1 for n = 3 or 5 mod 8
                    a_next = a_reg >> 1;
                    if (n_reg[2:0] == jac_pkg::MOD8_THREE ||
                        n_reg[2:0] == jac_pkg::MOD8_FIVE) begin
                        neg_next = ~neg_reg;
                    end
                end else if (borrow) begin
                    // reciprocity swap, both odd
                    a_next = n_reg;
                    n_next = a_reg;
                    if (a_reg[1:0] == jac_pkg::MOD4_THREE &&
                        n_reg[1:0] == jac_pkg::MOD4_THREE) begin
                        neg_next = ~neg_reg;
                    end
                end else begin
                    // a >= n, both odd: subtract leaves an even value
                    a_next = diff[OPERAND_WIDTH-1:0];
                end
            end
            ST_DONE: begin
                if (ctrl.ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sym_reg   <= jac_pkg::SYM_ZERO;
        end else begin
            state_reg <= state_next;
            sym_reg   <= sym_next;
        end
        a_reg   <= a_next;
        n_reg   <= n_next;
        neg_reg <= neg_next;
    end

    assign stat.idle   = (state_reg == ST_IDLE);
    assign stat.done   = (state_reg == ST_DONE);
    assign stat.symbol = sym_reg;

endmodule

/* rtl/jacobi_symbol_top.sv */
// Top level of the Jacobi symbol block: stream ports and result register.
// An even or zero modulus yields symbol 0 without iterating; otherwise the
//   engine runs the halvings, subtractions and swaps of the binary Jacobi
//   loop, data dependent.
// Throughput: one item at a time; the subtractor loop and m_tready set the rate.
// Reset: aresetn is synchronous, active low, and empties engine and output.
module jacobi_symbol_top #(
    parameter int unsigned OPERAND_WIDTH = jac_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: argument_a [63:0], modulus_n [127:64]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jac_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    // m_tdata: symbol_value [1:0], zero fill [7:2]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [jac_pkg::M_TDATA_WIDTH-1:0]   m_tdata
);

    jac_pkg::jac_ctrl_t     ctrl;
    jac_pkg::jac_stat_t     stat;

    logic [OPERAND_WIDTH-1:0]   op_a;
    logic [OPERAND_WIDTH-1:0]   op_n;
    logic                       out_free;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [1:0]                 sym_reg, sym_next;

    // Cut both operands to the working width
    assign op_a = s_tdata[OPERAND_WIDTH-1:0];
    assign op_n = s_tdata[jac_pkg::FIELD_WIDTH +: OPERAND_WIDTH];

    // Take a new transfer whenever the engine is idle, even while a result waits
    assign s_tready = stat.idle;

    // Output register is free when empty or being drained this cycle
    assign out_free  = !m_tvalid_reg || m_tready;
    assign ctrl.start = s_tvalid && stat.idle;
    assign ctrl.ack   = stat.done && out_free;

    jac_core #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .op_a    (op_a),
        .op_n    (op_n),
        .stat    (stat)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        sym_next      = sym_reg;
        if (ctrl.ack) begin
            // move the finished symbol into the output register
            m_tvalid_next = 1'b1;
            sym_next      = stat.symbol;
        end else if (m_tready) begin
            // drop the result once its transfer completes
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        sym_reg <= sym_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(jac_pkg::M_TDATA_WIDTH - 2){1'b0}}, sym_reg};

endmodule

/* rtl/jac_checker.sv */
// Port-level assertions for the Jacobi symbol block and their bind.
module jac_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [jac_pkg::M_TDATA_WIDTH-1:0]   m_tdata
);

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only -1, 0 and +1 appear, with zero fill above
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == jac_pkg::SYM_ZERO ||
                      m_tdata[1:0] == jac_pkg::SYM_POS ||
                      m_tdata[1:0] == jac_pkg::SYM_NEG) &&
                     m_tdata[jac_pkg::M_TDATA_WIDTH-1:2] == '0)
        else $error("illegal symbol code");

    // One item at a time: no input transfer right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind jacobi_symbol_top jac_checker u_jac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
